// ===== rtl/core/sck_pkg.sv =====
// Package for the Salsa20/ChaCha20 keystream block generator.
// Holds the state type, constants, register indexes and quarter-round helpers.
`timescale 1ns / 1ps
`default_nettype none
package sck_pkg;
  localparam int RoundCount = 20;
  localparam int DoubleRounds = RoundCount / 2;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [31:0] TAU1   = 32'h3120646e;
  localparam logic [31:0] TAU2   = 32'h79622d36;

  localparam logic [2:0] REG_KEY_LO    = 3'd0;
  localparam logic [2:0] REG_KEY_MID   = 3'd1;
  localparam logic [2:0] REG_KEY_UPPER = 3'd2;
  localparam logic [2:0] REG_KEY_TOP   = 3'd3;
  localparam logic [2:0] REG_NONCE     = 3'd4;
  localparam logic [2:0] REG_ALG       = 3'd5;
  localparam logic [2:0] REG_SHORT     = 3'd6;

  typedef logic [15:0][31:0] state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // one column or diagonal pass: four quarter rounds on independent words
  function automatic state_t half_round(input state_t s, input logic chacha,
                                        input logic diag);
    state_t o;
    int q;
    int a, b, c, d;
    o = s;
    for (q = 0; q < 4; q++) begin
      if (chacha) begin
        a = q; b = diag ? 4 + ((q + 1) % 4) : 4 + q;
        c = diag ? 8 + ((q + 2) % 4) : 8 + q;
        d = diag ? 12 + ((q + 3) % 4) : 12 + q;
        o[a] = o[a] + o[b]; o[d] = rotl(o[d] ^ o[a], 16);
        o[c] = o[c] + o[d]; o[b] = rotl(o[b] ^ o[c], 12);
        o[a] = o[a] + o[b]; o[d] = rotl(o[d] ^ o[a], 8);
        o[c] = o[c] + o[d]; o[b] = rotl(o[b] ^ o[c], 7);
      end else begin
        a = 5 * q;
        b = diag ? 4 * q + ((q + 1) % 4) : 4 * ((q + 1) % 4) + q;
        c = diag ? 4 * q + ((q + 2) % 4) : 4 * ((q + 2) % 4) + q;
        d = diag ? 4 * q + ((q + 3) % 4) : 4 * ((q + 3) % 4) + q;
        o[b] = o[b] ^ rotl(o[a] + o[d], 7);
        o[c] = o[c] ^ rotl(o[b] + o[a], 9);
        o[d] = o[d] ^ rotl(o[c] + o[b], 13);
        o[a] = o[a] ^ rotl(o[d] + o[c], 18);
      end
    end
    return o;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/salsa_chacha_keystream_block.sv =====
// Top level of the Salsa20/ChaCha20 keystream block generator.
// Depends on sck_pkg and sck_round_stage.
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata[63:0] block_counter
// out_    | out | out_tvalid/tready  | tdata[39:0] index, word; tlast last_word
// cfg_    | in  | cfg_valid/ready    | cfg_index[2:0], cfg_data[63:0]
//
// A block passes an entry stage, one stage per double round and a final add
// stage, then a 16-word serializer. The serializer emits one word per cycle
// while out_tready is high, and counters are still taken while it emits; the
// pipeline keeps advancing while the final stage is free, and once a block
// waits there behind a busy serializer every stage and the input hold.
// Reset clears all valid bits, the configuration and the serializer state;
// stalls hold every stage.
`timescale 1ns / 1ps
`default_nettype none
module salsa_chacha_keystream_block (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] block_counter
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [3:0] word_index, [35:4] word_value
  output logic             out_tlast,  // last_word
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import sck_pkg::*;

  logic [63:0] key_lo_r, key_mid_r, key_up_r, key_top_r, nonce_r;
  logic alg_r, short_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_mid_r <= '0; key_up_r <= '0; key_top_r <= '0;
      nonce_r <= '0; alg_r <= 1'b0; short_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_LO:    key_lo_r  <= cfg_data;
        REG_KEY_MID:   key_mid_r <= cfg_data;
        REG_KEY_UPPER: key_up_r  <= cfg_data;
        REG_KEY_TOP:   key_top_r <= cfg_data;
        REG_NONCE:     nonce_r   <= cfg_data;
        REG_ALG:       alg_r     <= cfg_data[0];
        REG_SHORT:     short_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // build the initial state word layout for the selected cipher
  state_t init_c;
  logic [31:0] c1, c2;
  logic [7:0][31:0] key;
  always_comb begin
    key[0] = key_lo_r[31:0];  key[1] = key_lo_r[63:32];
    key[2] = key_mid_r[31:0]; key[3] = key_mid_r[63:32];
    if (short_r) begin
      key[7:4] = key[3:0];
      c1 = TAU1; c2 = TAU2;
    end else begin
      key[4] = key_up_r[31:0];  key[5] = key_up_r[63:32];
      key[6] = key_top_r[31:0]; key[7] = key_top_r[63:32];
      c1 = SIGMA1; c2 = SIGMA2;
    end
    if (alg_r) begin
      init_c[0] = SIGMA0; init_c[1] = c1; init_c[2] = c2; init_c[3] = SIGMA3;
      for (int i = 0; i < 8; i++) init_c[4 + i] = key[i];
      init_c[12] = in_tdata[31:0]; init_c[13] = in_tdata[63:32];
      init_c[14] = nonce_r[31:0];  init_c[15] = nonce_r[63:32];
    end else begin
      init_c[0] = SIGMA0; init_c[5] = c1; init_c[10] = c2; init_c[15] = SIGMA3;
      for (int i = 0; i < 4; i++) begin
        init_c[1 + i] = key[i];
        init_c[11 + i] = key[4 + i];
      end
      init_c[6] = nonce_r[31:0];  init_c[7] = nonce_r[63:32];
      init_c[8] = in_tdata[31:0]; init_c[9] = in_tdata[63:32];
    end
  end

  // pipeline advances whenever the final stage is empty or being drained
  logic adv;
  logic fin_v_r;
  logic load_ser;
  logic ser_busy_r;
  logic [3:0] idx_r;

  // serializer takes the final block when idle or finishing its last word
  assign load_ser = fin_v_r && (!ser_busy_r || (out_tready && idx_r == 4'd15));
  assign adv = !fin_v_r || load_ser;
  assign in_tready = adv;

  logic   e_v_r, e_ch_r;
  state_t e_s_r;
  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= in_tvalid;
    if (adv) begin
      e_s_r <= init_c;
      e_ch_r <= alg_r;
    end
  end

  logic   [DoubleRounds:0] v_w;
  logic   [DoubleRounds:0] ch_w;
  state_t s_w [DoubleRounds+1];
  state_t i_w [DoubleRounds+1];
  assign v_w[0] = e_v_r;
  assign ch_w[0] = e_ch_r;
  assign s_w[0] = e_s_r;
  assign i_w[0] = e_s_r;

  for (genvar g = 0; g < DoubleRounds; g++) begin : g_dr
    sck_round_stage u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(v_w[g]), .chacha(ch_w[g]),
      .s_in(s_w[g]), .init_in(i_w[g]), .out_v(v_w[g+1]), .s_out(s_w[g+1]),
      .init_out(i_w[g+1]), .chacha_out(ch_w[g+1])
    );
  end

  // feed-forward add into the final stage
  state_t fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (adv) fin_v_r <= v_w[DoubleRounds];
    if (adv) begin
      for (int i = 0; i < 16; i++)
        fin_r[i] <= s_w[DoubleRounds][i] + i_w[DoubleRounds][i];
    end
  end

  // serializer: hold a block, advance one word per accepted transaction
  state_t ser_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_busy_r <= 1'b0;
      idx_r <= 4'd0;
    end else if (load_ser) begin
      ser_busy_r <= 1'b1;
      idx_r <= 4'd0;
    end else if (ser_busy_r && out_tready) begin
      idx_r <= idx_r + 4'd1;
      if (idx_r == 4'd15) ser_busy_r <= 1'b0;
    end
    if (load_ser) ser_r <= fin_r;
  end

  assign out_tvalid = ser_busy_r;
  assign out_tdata = {4'd0, ser_r[idx_r], idx_r};
  assign out_tlast = (idx_r == 4'd15);
endmodule
`default_nettype wire

// ===== rtl/core/sck_round_stage.sv =====
// One double-round pipeline stage with stall-aware valid tracking.
// Depends on sck_pkg for the state type and half_round.
`timescale 1ns / 1ps
`default_nettype none
module sck_round_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_v,
  input  wire logic            chacha,
  input  wire sck_pkg::state_t s_in,
  input  wire sck_pkg::state_t init_in,
  output logic                 out_v,
  output sck_pkg::state_t      s_out,
  output sck_pkg::state_t      init_out,
  output logic                 chacha_out
);
  import sck_pkg::*;
  logic v_r;
  state_t s_r, init_r;
  logic ch_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
    if (adv) begin
      s_r    <= half_round(half_round(s_in, chacha, 1'b0), chacha, 1'b1);
      init_r <= init_in;
      ch_r   <= chacha;
    end
  end
  assign out_v = v_r;
  assign s_out = s_r;
  assign init_out = init_r;
  assign chacha_out = ch_r;
endmodule
`default_nettype wire

// ===== rtl/core/sck_checker.sv =====
// Port-level checker for the keystream block generator, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module sck_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[3:0] == 4'hf))) else $error("tlast");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1))
    else $error("index step");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("hold");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'd0) else $error("pad");
endmodule

bind salsa_chacha_keystream_block sck_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);
`default_nettype wire
